// File: hw/rtl/ffud_pkg.sv
// Shared types and codes for the form field URL decoder.
// No dependencies; ffud_cfg_if, ffud_front, ffud_queue, ffud_back and the core use this package.
`default_nettype none

package ffud_pkg;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 64;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegNameLow    = 2'd0;
  localparam logic [CfgIndexW-1:0] RegNameHigh   = 2'd1;
  localparam logic [CfgIndexW-1:0] RegNameLength = 2'd2;
  localparam logic [CfgIndexW-1:0] RegMaxValue   = 2'd3;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       value_end;
    logic       found;
  } res_t;

  // Up to two results per input byte, pushed into the queue in order
  typedef struct packed {
    logic [1:0]       count;
    res_t [1:0]       item;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/ffud_in_if.sv
// Body byte channel: valid/ready handshake with byte and last flag.
// No dependencies.
`default_nettype none

interface ffud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ffud_out_if.sv
// Result channel: valid/ready handshake with one decoded result item.
// No dependencies.
`default_nettype none

interface ffud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       value_end;
  logic       found;

  modport source (output valid, output out_byte, output byte_valid, output value_end,
                  output found, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input value_end,
                input found, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ffud_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on ffud_pkg for field widths.
`default_nettype none

interface ffud_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ffud_pkg::CfgIndexW-1:0] index;
  logic [ffud_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ffud_front.sv
// Front end: config registers, field name match and percent decode state machine.
// Produces zero to two results per accepted byte. Depends on ffud_pkg, ffud_in_if, ffud_cfg_if.
`default_nettype none

module ffud_front (
  input  wire logic            clk,
  input  wire logic            rst,
  ffud_in_if.sink              body,
  ffud_cfg_if.sink             cfg,
  input  wire logic            room,
  output ffud_pkg::push_t      push
);

  localparam logic [2:0] PhName  = 3'd0;
  localparam logic [2:0] PhSkip  = 3'd1;
  localparam logic [2:0] PhValue = 3'd2;
  localparam logic [2:0] PhPct1  = 3'd3;
  localparam logic [2:0] PhPct2  = 3'd4;
  localparam logic [2:0] PhDone  = 3'd5;

  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] DigitMask = 8'h1F;
  localparam logic [4:0] MaxNameChars = 5'd16;
  localparam logic [7:0] ResetMaxValue = 8'd63;

  function automatic ffud_pkg::res_t mk(input logic [7:0] b, input logic v,
                                        input logic e, input logic f);
    ffud_pkg::res_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.value_end  = e;
    r.found      = f;
    return r;
  endfunction

  function automatic logic [7:0] digit(input logic [7:0] c);
    return (c >= CharA) ? ((c & DigitMask) + 8'd9) : (c - CharZero);
  endfunction

  // Configuration
  logic [63:0] field_name_low;
  logic [63:0] field_name_high;
  logic [4:0]  field_name_length;
  logic [7:0]  max_value_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_name_low    <= '0;
      field_name_high   <= '0;
      field_name_length <= '0;
      max_value_length  <= ResetMaxValue;
    end else if (cfg.valid) begin
      case (cfg.index)
        ffud_pkg::RegNameLow:    field_name_low    <= cfg.data;
        ffud_pkg::RegNameHigh:   field_name_high   <= cfg.data;
        ffud_pkg::RegNameLength: field_name_length <= cfg.data[4:0];
        ffud_pkg::RegMaxValue:   max_value_length  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Parser state
  logic [2:0] phase, phase_next;
  logic [4:0] name_position, name_position_next;
  logic [7:0] held_high_digit, held_high_digit_next;
  logic [7:0] value_count, value_count_next;

  logic         accept;
  logic [7:0]   b;
  logic         last;
  logic [4:0]   len;
  logic [127:0] name_all;
  logic [7:0]   name_char;
  logic [7:0]   d_hi, d_lo, decoded;

  assign accept    = body.valid && room;
  assign body.ready = room;
  assign b         = body.in_byte;
  assign last      = body.in_last;
  assign len       = (field_name_length > MaxNameChars) ? MaxNameChars : field_name_length;
  assign name_all  = {field_name_high, field_name_low};
  assign name_char = name_all[{name_position[3:0], 3'b000} +: 8];
  assign d_hi      = digit(held_high_digit);
  assign d_lo      = digit(b);
  assign decoded   = {d_hi[3:0], 4'b0000} + d_lo;

  logic [1:0]           n;
  ffud_pkg::res_t [1:0] res;
  logic                 matched;
  // first step: one literal/decoded byte; second step: an ordinary value byte
  logic                 a_put, a_ends, a_end;
  logic [7:0]           a_byte;
  logic                 p_do, p_ends, p_end;
  logic [7:0]           p_byte;

  always_comb begin
    phase_next           = phase;
    name_position_next   = name_position;
    held_high_digit_next = held_high_digit;
    value_count_next     = value_count;
    n       = '0;
    res     = '0;
    matched = 1'b0;
    a_put   = 1'b0;
    a_ends  = 1'b0;
    a_end   = 1'b0;
    a_byte  = '0;
    p_do    = 1'b0;
    p_ends  = 1'b0;
    p_end   = 1'b0;
    p_byte  = '0;

    case (phase)
      PhName, PhSkip: begin
        if (b == 8'h00) begin
          phase_next = PhDone;
          res[n[0]] = mk(8'h00, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
        end else if (phase == PhSkip) begin
          if (b == CharAmp) begin
            phase_next = PhName;
            name_position_next = '0;
          end
        end else if (name_position < len) begin
          if (b == name_char) begin
            name_position_next = name_position + 5'd1;
          end else if (b == CharAmp) begin
            name_position_next = '0;
          end else begin
            phase_next = PhSkip;
          end
        end else if (b == CharEq) begin
          matched = 1'b1;
        end else if (b == CharAmp) begin
          name_position_next = '0;
        end else begin
          phase_next = PhSkip;
        end

        if (matched) begin
          value_count_next = '0;
          if (max_value_length == 8'd0 || last) begin
            phase_next = PhDone;
            res[n[0]] = mk(8'h00, 1'b0, 1'b1, 1'b1);
            n = n + 2'd1;
          end else begin
            phase_next = PhValue;
          end
        end else if (last && phase_next != PhDone) begin
          res[n[0]] = mk(8'h00, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
        end
      end
      PhValue, PhPct1, PhPct2: begin
        if (value_count >= max_value_length) begin
          // limit reached, held escape is dropped
          phase_next = PhDone;
          res[n[0]] = mk(8'h00, 1'b0, 1'b1, 1'b1);
          n = n + 2'd1;
        end else if (phase == PhValue) begin
          if (b == 8'h00) begin
            phase_next = PhDone;
            res[n[0]] = mk(8'h00, 1'b0, 1'b1, 1'b1);
            n = n + 2'd1;
          end else begin
            p_do   = 1'b1;
            p_byte = b;
            p_ends = last;
          end
        end else if (phase == PhPct1) begin
          if (b == 8'h00) begin
            a_put  = 1'b1;
            a_byte = CharPct;
            a_ends = 1'b1;
          end else if (last) begin
            // short escape: literal '%' then this byte as plain value
            phase_next = PhValue;
            a_put  = 1'b1;
            a_byte = CharPct;
            p_do   = 1'b1;
            p_byte = b;
            p_ends = 1'b1;
          end else begin
            held_high_digit_next = b;
            phase_next = PhPct2;
          end
        end else begin
          phase_next = PhValue;
          if (b != 8'h00) begin
            a_put  = 1'b1;
            a_byte = decoded;
            a_ends = last;
          end else begin
            a_put  = 1'b1;
            a_byte = CharPct;
            p_do   = 1'b1;
            p_byte = held_high_digit;
            p_ends = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (a_put) begin
      value_count_next = value_count_next + 8'd1;
      a_end = a_ends || (value_count_next >= max_value_length);
      if (a_end) begin
        phase_next = PhDone;
      end
      res[n[0]] = mk(a_byte, 1'b1, a_end, 1'b1);
      n = n + 2'd1;
    end

    if (p_do && phase_next == PhValue) begin
      if (p_byte == CharAmp) begin
        phase_next = PhDone;
        res[n[0]] = mk(8'h00, 1'b0, 1'b1, 1'b1);
        n = n + 2'd1;
      end else if (p_byte == CharPct && !p_ends) begin
        phase_next = PhPct1;
      end else begin
        value_count_next = value_count_next + 8'd1;
        p_end = p_ends || (value_count_next >= max_value_length);
        if (p_end) begin
          phase_next = PhDone;
        end
        res[n[0]] = mk((p_byte == CharPlus) ? CharSpace : p_byte, 1'b1, p_end, 1'b1);
        n = n + 2'd1;
      end
    end

    if (last) begin
      phase_next           = PhName;
      name_position_next   = '0;
      held_high_digit_next = '0;
      value_count_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PhName;
      name_position   <= '0;
      held_high_digit <= '0;
      value_count     <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      name_position   <= name_position_next;
      held_high_digit <= held_high_digit_next;
      value_count     <= value_count_next;
    end
  end

  assign push.count = accept ? n : 2'd0;
  assign push.item  = res;

endmodule

`default_nettype wire

// File: hw/rtl/ffud_queue.sv
// Result queue between front and back: takes up to two items per cycle,
// gives one. Depends on ffud_pkg.
`default_nettype none

module ffud_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ffud_pkg::push_t            push,
  input  wire logic                       pop,
  output logic                            head_valid,
  output ffud_pkg::res_t                  head,
  output logic [$clog2(DEPTH+1)-1:0]      level
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  ffud_pkg::res_t mem [DEPTH];
  logic [PW-1:0]  rd_ptr, wr_ptr;
  logic [PW-1:0]  wr_plus1, wr_plus2;

  assign wr_plus1   = nxt(wr_ptr);
  assign wr_plus2   = nxt(wr_plus1);
  assign head_valid = (level != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.item[0];
    end
    if (push.count == 2'd2) begin
      mem[wr_plus1] <= push.item[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= nxt(rd_ptr);
      end
      case (push.count)
        2'd1:    wr_ptr <= wr_plus1;
        2'd2:    wr_ptr <= wr_plus2;
        default: wr_ptr <= wr_ptr;
      endcase
      level <= level + CW'(push.count) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ffud_back.sv
// Back end: output register that drains the result queue onto the result channel.
// Depends on ffud_pkg and ffud_out_if.
`default_nettype none

module ffud_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire ffud_pkg::res_t head,
  output logic                pop,
  ffud_out_if.source          result
);

  logic           valid;
  ffud_pkg::res_t data;
  logic           load;

  assign load = !valid || result.ready;
  assign pop  = load && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data <= head;
    end
  end

  assign result.valid      = valid;
  assign result.out_byte   = data.out_byte;
  assign result.byte_valid = data.byte_valid;
  assign result.value_end  = data.value_end;
  assign result.found      = data.found;

endmodule

`default_nettype wire

// File: hw/rtl/form_field_url_decoder_core.sv
// A result passes from the transfer of its body byte through the result queue
// (written at the transfer edge) and then the output register onto the result channel.
// Throughput: one body byte per cycle; a byte that yields two results gives two
// output transfers, and the body channel stalls while the result queue has fewer
// than two free entries. Reset (rst, synchronous) empties the queue and output
// register, sets parser state to field start, name empty and value limit 63.
`default_nettype none

module form_field_url_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  ffud_in_if.sink   body,
  ffud_out_if.source result,
  ffud_cfg_if.sink  cfg
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ffud_pkg::push_t push;
  ffud_pkg::res_t  head;
  logic            head_valid;
  logic            pop;
  logic [CW-1:0]   level;
  logic            room;

  assign room = (level <= CW'(QUEUE_DEPTH - 2));

  ffud_front u_front (
    .clk  (clk),
    .rst  (rst),
    .body (body),
    .cfg  (cfg),
    .room (room),
    .push (push)
  );

  ffud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  ffud_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= CW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_on_transfer: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> body.valid && body.ready)
    else $error("results pushed without a body transfer");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.byte_valid |-> result.value_end && result.out_byte == 8'h00)
    else $error("result without data byte is not an end marker");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: dv/form_field_url_decoder_core_tb.sv
// Testbench for form_field_url_decoder_core: directed bodies, then random form bodies under
// several handshake idle/stall mixes, each result checked against typed expectations or a field extractor model.
// Depends on ffud_pkg, ffud_in_if, ffud_out_if, ffud_cfg_if and the core RTL.
`default_nettype none

module form_field_url_decoder_core_tb;

  localparam int          NameMax      = 16;
  localparam int          SettleCycles = 8;
  localparam int unsigned CycleLimit   = 400000;

  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [2:0] {PhName, PhSkip, PhValue, PhPct1, PhPct2, PhDone} parse_phase_t;

  typedef struct packed {
    logic                           cfg_write;
    logic [ffud_pkg::CfgIndexW-1:0] reg_index;
    logic [63:0]                    value;
    logic                           last;
    logic                           typed;
    logic [1:0]                     typed_count;
    ffud_pkg::res_t                 first_res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  ffud_in_if  body_ch ();
  ffud_out_if result_ch ();
  ffud_cfg_if cfg_ch ();

  form_field_url_decoder_core uut (
    .clk   (clk),
    .rst   (rst),
    .body  (body_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always #1 clk = ~clk;

  // Extractor model state and its copy of the registers
  logic [63:0]  name_low_m  = '0;
  logic [63:0]  name_high_m = '0;
  logic [4:0]   name_len_m  = '0;
  logic [7:0]   max_len_m   = 8'd63;
  parse_phase_t phase_m     = PhName;
  logic [4:0]   name_pos_m  = '0;
  logic [7:0]   held_hi_m   = '0;
  logic [7:0]   value_cnt_m = '0;

  ffud_pkg::res_t decoded_q[$];
  ffud_pkg::res_t pending_results[$];
  logic [7:0]     body_bytes[$];
  int             send_idle_pct = 0;
  int             stall_pct     = 0;
  int             error_count   = 0;
  int unsigned    cycle_count   = 0;
  plan_row_t      directed_plan [30];

  function automatic ffud_pkg::res_t want(logic [7:0] b, logic v, logic e, logic f);
    ffud_pkg::res_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.value_end  = e;
    r.found      = f;
    return r;
  endfunction

  function automatic void emit(logic [7:0] b, logic v, logic e, logic f);
    decoded_q.push_back(want(b, v, e, f));
  endfunction

  function automatic logic [7:0] name_char(int k);
    if (k < 8) return name_low_m[8*k +: 8];
    return name_high_m[8*(k-8) +: 8];
  endfunction

  function automatic int name_len_eff();
    return (name_len_m > NameMax) ? NameMax : int'(name_len_m);
  endfunction

  // Hex digit weight; deliberately unchecked, non-digits wrap
  function automatic logic [7:0] digit_weight(logic [7:0] c);
    return (c >= 8'd65) ? (c & 8'h1f) + 8'd9 : c - 8'd48;
  endfunction

  function automatic void put_value(logic [7:0] b, logic body_ends);
    logic close;
    value_cnt_m = value_cnt_m + 8'd1;
    close = body_ends || (value_cnt_m >= max_len_m);
    if (close) phase_m = PhDone;
    emit(b, 1'b1, close, 1'b1);
  endfunction

  function automatic void plain_value(logic [7:0] b, logic body_ends);
    if (b == ChAmp) begin
      phase_m = PhDone;
      emit(8'h00, 1'b0, 1'b1, 1'b1);
    end else if (b == ChPct && !body_ends) begin
      phase_m = PhPct1;
    end else begin
      put_value((b == ChPlus) ? ChSpace : b, body_ends);
    end
  endfunction

  // Advances the model by one body byte; results land in decoded_q
  function automatic void decode_byte(logic [7:0] b, logic last);
    logic       matched;
    logic [7:0] hi;
    decoded_q.delete();
    matched = 1'b0;
    if (phase_m == PhName || phase_m == PhSkip) begin
      if (b == 8'h00) begin
        phase_m = PhDone;
        emit(8'h00, 1'b0, 1'b1, 1'b0);
      end else if (phase_m == PhSkip) begin
        if (b == ChAmp) begin
          phase_m    = PhName;
          name_pos_m = '0;
        end
      end else if (name_pos_m < name_len_eff()) begin
        if (b == name_char(name_pos_m)) name_pos_m = name_pos_m + 5'd1;
        else if (b == ChAmp) name_pos_m = '0;
        else phase_m = PhSkip;
      end else if (b == ChEq) begin
        matched = 1'b1;
      end else if (b == ChAmp) begin
        name_pos_m = '0;
      end else begin
        phase_m = PhSkip;
      end
      if (matched) begin
        value_cnt_m = '0;
        if (max_len_m == 8'd0 || last) begin
          phase_m = PhDone;
          emit(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
          phase_m = PhValue;
        end
      end else if (last && phase_m != PhDone) begin
        emit(8'h00, 1'b0, 1'b1, 1'b0);
      end
    end else if (phase_m != PhDone) begin
      if (value_cnt_m >= max_len_m) begin
        // limit was lowered under a live value; any held escape is dropped
        phase_m = PhDone;
        emit(8'h00, 1'b0, 1'b1, 1'b1);
      end else if (phase_m == PhValue) begin
        if (b == 8'h00) begin
          phase_m = PhDone;
          emit(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
          plain_value(b, last);
        end
      end else if (phase_m == PhPct1) begin
        if (b == 8'h00) begin
          put_value(ChPct, 1'b1);
        end else if (last) begin
          phase_m = PhValue;
          put_value(ChPct, 1'b0);
          if (phase_m == PhValue) plain_value(b, 1'b1);
        end else begin
          held_hi_m = b;
          phase_m   = PhPct2;
        end
      end else begin
        hi      = held_hi_m;
        phase_m = PhValue;
        if (b != 8'h00) begin
          put_value(digit_weight(hi) * 8'd16 + digit_weight(b), last);
        end else begin
          put_value(ChPct, 1'b0);
          if (phase_m == PhValue) plain_value(hi, 1'b1);
        end
      end
    end
    if (last) begin
      phase_m     = PhName;
      name_pos_m  = '0;
      held_hi_m   = '0;
      value_cnt_m = '0;
    end
  endfunction

  function automatic plan_row_t byte_row(logic [7:0] b, logic l);
    plan_row_t r;
    r       = '0;
    r.value = 64'(b);
    r.last  = l;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [7:0] b, logic l, logic [1:0] n,
                                          ffud_pkg::res_t res);
    plan_row_t r;
    r             = byte_row(b, l);
    r.typed       = 1'b1;
    r.typed_count = n;
    r.first_res   = res;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [ffud_pkg::CfgIndexW-1:0] idx,
                                        logic [63:0] val);
    plan_row_t r;
    r           = '0;
    r.cfg_write = 1'b1;
    r.reg_index = idx;
    r.value     = val;
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] hex_char();
    case ($urandom_range(2))
      0: return 8'h30 + 8'($urandom_range(9));
      1: return 8'h41 + 8'($urandom_range(5));
      default: return 8'h61 + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [63:0] rand_name_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++)
      w[8*k +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : letter();
    return w;
  endfunction

  function automatic void append_name(logic use_target);
    int n;
    if (use_target) begin
      n = name_len_eff();
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(39) == 0)
          body_bytes.push_back(($urandom_range(1) != 0) ? ChAmp : 8'($urandom_range(255, 1)));
        else
          body_bytes.push_back(name_char(k));
      end
    end else begin
      n = $urandom_range(4);
      for (int k = 0; k < n; k++) body_bytes.push_back(letter());
    end
  endfunction

  function automatic void append_value_token();
    case ($urandom_range(9))
      0: body_bytes.push_back(ChPlus);
      1, 2: begin
        body_bytes.push_back(ChPct);
        body_bytes.push_back(hex_char());
        body_bytes.push_back(hex_char());
      end
      3: begin
        body_bytes.push_back(ChPct);
        body_bytes.push_back(8'($urandom_range(255, 1)));
        body_bytes.push_back(8'($urandom_range(255, 1)));
      end
      4: body_bytes.push_back(8'($urandom_range(255, 1)));
      default: body_bytes.push_back(letter());
    endcase
  endfunction

  // Mostly well formed name=value&... bodies, some noise
  function automatic void build_body();
    int nfields;
    int vlen;
    body_bytes.delete();
    if ($urandom_range(9) < 2) begin
      vlen = $urandom_range(12, 1);
      for (int k = 0; k < vlen; k++)
        body_bytes.push_back(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
    end else begin
      nfields = $urandom_range(3, 1);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) body_bytes.push_back(ChAmp);
        append_name($urandom_range(9) < 6);
        if ($urandom_range(9) != 0) body_bytes.push_back(ChEq);
        vlen = (max_len_m >= 8'd200 && $urandom_range(39) == 0) ?
               $urandom_range(300, 200) : $urandom_range(6);
        for (int k = 0; k < vlen; k++) append_value_token();
      end
      if ($urandom_range(7) == 0) begin
        body_bytes.push_back(ChPct);
        if ($urandom_range(1) != 0) body_bytes.push_back(hex_char());
      end
      if (body_bytes.size() == 0) body_bytes.push_back(ChEq);
      if ($urandom_range(15) == 0) body_bytes[$urandom_range(body_bytes.size() - 1)] = 8'h00;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      body_ch.valid <= 1'b0;
      @(posedge clk);
    end
    body_ch.valid   <= 1'b1;
    body_ch.in_byte <= b;
    body_ch.in_last <= last;
    @(posedge clk);
    while (!body_ch.ready) @(posedge clk);
  endtask

  // Transfer one byte and run the model on it
  task automatic accept_byte(logic [7:0] b, logic last);
    send_byte(b, last);
    decode_byte(b, last);
  endtask

  // Body valid drops; bytes that give no result may still be in flight after the drain
  task automatic wait_idle();
    body_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Leaves cfg valid high so back-to-back writes need no gap; caller drops it
  task automatic write_reg(logic [ffud_pkg::CfgIndexW-1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      ffud_pkg::RegNameLow:    name_low_m  = val;
      ffud_pkg::RegNameHigh:   name_high_m = val;
      ffud_pkg::RegNameLength: name_len_m  = val[4:0];
      ffud_pkg::RegMaxValue:   max_len_m   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [63:0] low, logic [63:0] high, logic [4:0] len,
                               logic [7:0] max_v);
    wait_idle();
    write_reg(ffud_pkg::RegNameLow, low);
    write_reg(ffud_pkg::RegNameHigh, high);
    write_reg(ffud_pkg::RegNameLength, 64'(len));
    write_reg(ffud_pkg::RegMaxValue, 64'(max_v));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_traffic(int n_items, int idle_pct, int stall);
    int sent;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent          = 0;
    while (sent < n_items) begin
      build_body();
      if ($urandom_range(19) == 0) wait_idle();
      foreach (body_bytes[i]) begin
        accept_byte(body_bytes[i], i == body_bytes.size() - 1);
        foreach (decoded_q[k]) pending_results.push_back(decoded_q[k]);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : result_sink
    ffud_pkg::res_t got;
    ffud_pkg::res_t exp_r;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.out_byte   = result_ch.out_byte;
        got.byte_valid = result_ch.byte_valid;
        got.value_end  = result_ch.value_end;
        got.found      = result_ch.found;
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer: expected none, actual %h", $time, got);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("out_byte", exp_r.out_byte, got.out_byte);
          check_field("byte_valid", 8'(exp_r.byte_valid), 8'(got.byte_valid));
          check_field("value_end", 8'(exp_r.value_end), 8'(got.value_end));
          check_field("found", 8'(exp_r.found), 8'(got.found));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    body_ch.valid   = 1'b0;
    body_ch.in_byte = '0;
    body_ch.in_last = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;

    // Empty name after reset: a body starting with '=' matches at once
    directed_plan = '{
      typed_row(8'h00, 1'b1, 2'd1, want(8'h00, 1'b0, 1'b1, 1'b0)),
      byte_row("=", 1'b0),
      typed_row("+", 1'b0, 2'd1, want(8'h20, 1'b1, 1'b0, 1'b1)),
      byte_row("%", 1'b0),
      byte_row("F", 1'b0),
      typed_row("f", 1'b0, 2'd1, want(8'hff, 1'b1, 1'b0, 1'b1)),
      byte_row("%", 1'b0),
      byte_row("a", 1'b1),  // short escape: literal '%' then 'a'
      byte_row("=", 1'b0),
      byte_row("k", 1'b0),
      typed_row("&", 1'b1, 2'd1, want(8'h00, 1'b0, 1'b1, 1'b1)),
      reg_row(ffud_pkg::RegNameLow, 64'h6261),
      reg_row(ffud_pkg::RegNameLength, 64'd2),
      reg_row(ffud_pkg::RegMaxValue, 64'd1),
      byte_row("a", 1'b0),
      byte_row("&", 1'b0),  // mismatching '&' restarts the name
      byte_row("a", 1'b0),
      byte_row("b", 1'b0),
      byte_row("=", 1'b0),
      typed_row("Z", 1'b0, 2'd1, want(8'h5a, 1'b1, 1'b1, 1'b1)),
      typed_row("q", 1'b1, 2'd0, '0),
      reg_row(ffud_pkg::RegMaxValue, 64'd3),
      byte_row("a", 1'b0),
      byte_row("b", 1'b0),
      byte_row("=", 1'b0),
      typed_row("x", 1'b0, 2'd1, want(8'h78, 1'b1, 1'b0, 1'b1)),
      byte_row("%", 1'b0),
      reg_row(ffud_pkg::RegMaxValue, 64'd1),  // limit lowered with an escape held
      typed_row("4", 1'b1, 2'd1, want(8'h00, 1'b0, 1'b1, 1'b1)),
      typed_row("b", 1'b1, 2'd1, want(8'h00, 1'b0, 1'b1, 1'b0))
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].cfg_write) begin
        wait_idle();
        write_reg(directed_plan[i].reg_index, directed_plan[i].value);
        cfg_ch.valid <= 1'b0;
      end else begin
        accept_byte(directed_plan[i].value[7:0], directed_plan[i].last);
        if (directed_plan[i].typed) begin
          if (directed_plan[i].typed_count != 2'd0)
            pending_results.push_back(directed_plan[i].first_res);
        end else begin
          foreach (decoded_q[k]) pending_results.push_back(decoded_q[k]);
        end
      end
    end

    set_registers(rand_name_word(), rand_name_word(), 5'($urandom_range(8, 1)),
                  8'($urandom_range(20, 4)));
    run_traffic(150, 0, 0);
    set_registers(rand_name_word(), {64{1'b1}}, 5'd16, 8'd255);
    run_traffic(150, 53, 0);
    set_registers(rand_name_word(), rand_name_word(), 5'd31, 8'd0);
    run_traffic(150, 0, 53);
    set_registers(64'd0, 64'd0, 5'd0, 8'd1);
    run_traffic(150, 32, 32);
    set_registers(rand_name_word(), rand_name_word(), 5'($urandom_range(31)),
                  8'($urandom_range(255)));
    run_traffic(150, 0, 0);
    set_registers(rand_name_word(), rand_name_word(), 5'($urandom_range(16)),
                  8'($urandom_range(40)));
    run_traffic(150, 32, 32);

    wait_idle();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
